[hw/rtl/hogob_pkg.sv]
// ----------------------------------------------------------------------------
// hogob_pkg
// Shared constants and direction tables for the HOG orientation binning block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package hogob_pkg;

    localparam int SAMPLE_BITS_DEF = 12;
    localparam int NUM_CH          = 3;
    localparam int NUM_TAPS        = 4;
    localparam int NUM_DIRS        = 9;
    localparam int GROUP_SIZE      = 3;
    localparam int NUM_GROUPS      = NUM_DIRS / GROUP_SIZE;
    localparam int SHIFT_W         = 4;
    localparam int COEF_W          = 16;
    localparam int W_BIN           = 5;
    localparam int W_MAG           = 13;
    localparam int W_GRAD          = 13;
    localparam int OUT_W           = ((W_BIN + W_MAG + 2 * W_GRAD + 7) / 8) * 8;

    typedef logic [W_BIN-1:0] bin_t;

    // Unit vector components in Q1.14, 20 degree steps
    function automatic logic signed [COEF_W-1:0] unit_u(input int dir);
        logic signed [COEF_W-1:0] c;
        case (dir)
            0:       c = 16'sd16384;
            1:       c = 16'sd15396;
            2:       c = 16'sd12550;
            3:       c = 16'sd8192;
            4:       c = 16'sd2844;
            5:       c = -16'sd2844;
            6:       c = -16'sd8192;
            7:       c = -16'sd12550;
            8:       c = -16'sd15396;
            default: c = 16'sd0;
        endcase
        return c;
    endfunction

    function automatic logic signed [COEF_W-1:0] unit_v(input int dir);
        logic signed [COEF_W-1:0] c;
        case (dir)
            0:       c = 16'sd0;
            1:       c = 16'sd5603;
            2:       c = 16'sd10532;
            3:       c = 16'sd14189;
            4:       c = 16'sd16135;
            5:       c = 16'sd16135;
            6:       c = 16'sd14189;
            7:       c = 16'sd10532;
            8:       c = 16'sd5603;
            default: c = 16'sd0;
        endcase
        return c;
    endfunction

endpackage

[hw/rtl/hogob_chan_lane.sv]
// ----------------------------------------------------------------------------
// hogob_chan_lane
// One colour channel: bit-depth shift, central differences and L1 magnitude.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hogob_chan_lane #(
    parameter int SAMPLE_BITS = hogob_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                 clk,
    input  logic                                 en,
    input  logic [hogob_pkg::SHIFT_W-1:0]        shift,
    input  logic [SAMPLE_BITS-1:0]               next_row,
    input  logic [SAMPLE_BITS-1:0]               prev_row,
    input  logic [SAMPLE_BITS-1:0]               next_col,
    input  logic [SAMPLE_BITS-1:0]               prev_col,
    output logic signed [SAMPLE_BITS:0]          gx_reg,
    output logic signed [SAMPLE_BITS:0]          gy_reg,
    output logic [SAMPLE_BITS+1:0]               mag_reg
);

    localparam int GW = SAMPLE_BITS + 1;

    logic [SAMPLE_BITS-1:0] nr_s, pr_s, nc_s, pc_s;
    logic signed [GW-1:0]   gx_next, gy_next;
    logic [GW-1:0]          ax, ay;
    logic [GW:0]            mag_next;

    assign nr_s = next_row >> shift;
    assign pr_s = prev_row >> shift;
    assign nc_s = next_col >> shift;
    assign pc_s = prev_col >> shift;

    assign gx_next  = signed'({1'b0, nc_s}) - signed'({1'b0, pc_s});
    assign gy_next  = signed'({1'b0, nr_s}) - signed'({1'b0, pr_s});
    assign ax       = gx_next[GW-1] ? GW'(-gx_next) : GW'(gx_next);
    assign ay       = gy_next[GW-1] ? GW'(-gy_next) : GW'(gy_next);
    assign mag_next = {1'b0, ax} + {1'b0, ay};

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            gx_reg  <= gx_next;
            gy_reg  <= gy_next;
            mag_reg <= mag_next;
        end
    end

endmodule

[hw/rtl/hogob_dir_lane.sv]
// ----------------------------------------------------------------------------
// hogob_dir_lane
// One orientation direction: dot product with the unit vector, then the
// magnitude of the dot and its signed bin code.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hogob_dir_lane #(
    parameter int SAMPLE_BITS = hogob_pkg::SAMPLE_BITS_DEF,
    parameter int DIR         = 0
) (
    input  logic                                            clk,
    input  logic                                            en,
    input  logic signed [SAMPLE_BITS:0]                     gx,
    input  logic signed [SAMPLE_BITS:0]                     gy,
    output logic [SAMPLE_BITS+hogob_pkg::COEF_W+1:0]        val_reg,
    output hogob_pkg::bin_t                                 bin_reg
);

    localparam int GW = SAMPLE_BITS + 1;
    localparam int PW = GW + hogob_pkg::COEF_W;
    localparam int DW = PW + 1;
    localparam logic signed [hogob_pkg::COEF_W-1:0] U = hogob_pkg::unit_u(DIR);
    localparam logic signed [hogob_pkg::COEF_W-1:0] V = hogob_pkg::unit_v(DIR);
    localparam hogob_pkg::bin_t BIN_POS = hogob_pkg::W_BIN'(DIR);
    localparam hogob_pkg::bin_t BIN_NEG = hogob_pkg::W_BIN'(DIR + hogob_pkg::NUM_DIRS);

    logic signed [PW-1:0] pu_reg, pv_reg;
    logic signed [DW-1:0] dot;
    logic [DW-1:0]        val_next;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pu_reg <= PW'(gx * U);
            pv_reg <= PW'(gy * V);
        end
    end

    assign dot      = DW'(pu_reg) + DW'(pv_reg);
    assign val_next = dot[DW-1] ? DW'(-dot) : DW'(dot);

    // a zero dot keeps the positive code, so an all-zero gradient lands on bin 0
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            val_reg <= val_next;
            bin_reg <= dot[DW-1] ? BIN_NEG : BIN_POS;
        end
    end

endmodule

[hw/rtl/hogob_chan_select.sv]
// ----------------------------------------------------------------------------
// hogob_chan_select
// Picks the channel with the strongest L1 gradient; ties keep the lower one.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hogob_chan_select #(
    parameter int SAMPLE_BITS = hogob_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                                clk,
    input  logic                                                en,
    input  logic signed [hogob_pkg::NUM_CH-1:0][SAMPLE_BITS:0]  gx,
    input  logic signed [hogob_pkg::NUM_CH-1:0][SAMPLE_BITS:0]  gy,
    input  logic [hogob_pkg::NUM_CH-1:0][SAMPLE_BITS+1:0]       mag,
    output logic signed [SAMPLE_BITS:0]                         gx_reg,
    output logic signed [SAMPLE_BITS:0]                         gy_reg,
    output logic [SAMPLE_BITS+1:0]                              mag_reg
);

    logic signed [SAMPLE_BITS:0] bx, by;
    logic [SAMPLE_BITS+1:0]      bm;

    always_comb
    begin
        bx = gx[0];
        by = gy[0];
        bm = mag[0];
        for (int c = 1; c < hogob_pkg::NUM_CH; c++)
        begin
            if (mag[c] > bm)
            begin
                bx = gx[c];
                by = gy[c];
                bm = mag[c];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            gx_reg  <= bx;
            gy_reg  <= by;
            mag_reg <= bm;
        end
    end

endmodule

[hw/rtl/hogob_bin_merge.sv]
// ----------------------------------------------------------------------------
// hogob_bin_merge
// Two-level registered reduction of the direction lanes to the winning bin.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hogob_bin_merge #(
    parameter int VAL_W = 30
) (
    input  logic                                          clk,
    input  logic                                          en,
    input  logic [hogob_pkg::NUM_DIRS-1:0][VAL_W-1:0]     val,
    input  hogob_pkg::bin_t [hogob_pkg::NUM_DIRS-1:0]     bin,
    output hogob_pkg::bin_t                               bin_reg
);

    logic [hogob_pkg::NUM_GROUPS-1:0][VAL_W-1:0] gval_next, gval_reg;
    hogob_pkg::bin_t [hogob_pkg::NUM_GROUPS-1:0] gbin_next, gbin_reg;
    hogob_pkg::bin_t                             fbin;
    logic [VAL_W-1:0]                            fval;

    // lower index holds on a tie: replace only on strictly larger
    always_comb
    begin
        for (int g = 0; g < hogob_pkg::NUM_GROUPS; g++)
        begin
            gval_next[g] = val[g * hogob_pkg::GROUP_SIZE];
            gbin_next[g] = bin[g * hogob_pkg::GROUP_SIZE];
            for (int j = 1; j < hogob_pkg::GROUP_SIZE; j++)
            begin
                if (val[g * hogob_pkg::GROUP_SIZE + j] > gval_next[g])
                begin
                    gval_next[g] = val[g * hogob_pkg::GROUP_SIZE + j];
                    gbin_next[g] = bin[g * hogob_pkg::GROUP_SIZE + j];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            gval_reg <= gval_next;
            gbin_reg <= gbin_next;
        end
    end

    always_comb
    begin
        fval = gval_reg[0];
        fbin = gbin_reg[0];
        for (int g = 1; g < hogob_pkg::NUM_GROUPS; g++)
        begin
            if (gval_reg[g] > fval)
            begin
                fval = gval_reg[g];
                fbin = gbin_reg[g];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            bin_reg <= fbin;
        end
    end

endmodule

[hw/rtl/hog_gradient_orientation_bin_top.sv]
// ----------------------------------------------------------------------------
// hog_gradient_orientation_bin_top
// Per-pixel gradient and 18-bin signed orientation for HOG features.
//
// Input stream s_*: one word per pixel carrying the four axis neighbours of
// three colour channels. Output stream m_*: one word per input word with the
// orientation bin, L1 magnitude and the chosen channel's gradient.
// Config channel cfg_*: pixel_shift, always ready; write it while idle.
//
// Throughput is one word per cycle while the receiver keeps m_tready high. The
// path from the accepting edge to m_tvalid runs through six register stages:
// channel lanes, channel select, direction multiplies, dot sum and sign, then
// two levels of the bin merge tree; the last level is the output register. All
// stages advance together, so a stalled receiver holds every stage and drops
// s_tready in the same cycle; s_tready stays high while the output register is
// empty or being taken.
// Reset clears the valid flags and sets pixel_shift to zero; no clearing pass.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hog_gradient_orientation_bin_top #(
    parameter int SAMPLE_BITS = hogob_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // cfg_data: pixel_shift[3:0]
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [hogob_pkg::SHIFT_W-1:0]       cfg_data,
    // s_tdata, from bit 0 up: c0_next_row, c0_prev_row, c0_next_col, c0_prev_col,
    // then the same four for c1 and c2, SAMPLE_BITS each, zero padded to bytes
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [((hogob_pkg::NUM_CH * hogob_pkg::NUM_TAPS * SAMPLE_BITS + 7) / 8) * 8 - 1:0]
                                                s_tdata,
    // m_tdata, from bit 0 up: orient_bin[4:0], grad_mag[12:0], grad_x[12:0],
    // grad_y[12:0], zero padded to bytes
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [hogob_pkg::OUT_W-1:0]         m_tdata
);

    localparam int GW     = SAMPLE_BITS + 1;
    localparam int MW     = SAMPLE_BITS + 2;
    localparam int DW     = GW + hogob_pkg::COEF_W + 1;
    localparam int STAGES = 6;
    localparam int DLY    = 4;
    localparam int NCH    = hogob_pkg::NUM_CH;
    localparam int NDIR   = hogob_pkg::NUM_DIRS;
    localparam int PAD_W  = hogob_pkg::OUT_W - hogob_pkg::W_BIN - hogob_pkg::W_MAG
                            - 2 * hogob_pkg::W_GRAD;

    logic [hogob_pkg::SHIFT_W-1:0] shift_reg;
    logic [STAGES-1:0]             valid_reg;
    logic                          advance;

    logic signed [NCH-1:0][GW-1:0] ch_gx, ch_gy;
    logic [NCH-1:0][MW-1:0]        ch_mag;
    logic signed [GW-1:0]          sel_gx, sel_gy;
    logic [MW-1:0]                 sel_mag;

    logic signed [DLY-1:0][GW-1:0] dgx_reg, dgy_reg;
    logic [DLY-1:0][MW-1:0]        dmag_reg;

    logic [NDIR-1:0][DW-1:0]       dir_val;
    hogob_pkg::bin_t [NDIR-1:0]    dir_bin;
    hogob_pkg::bin_t               out_bin;

    logic [31:0]                   mag_ext;
    logic signed [31:0]            gx_ext, gy_ext;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shift_reg <= '0;
        end
        else if (cfg_valid)
        begin
            shift_reg <= cfg_data;
        end
    end

    // the whole pipe moves as one; hold everything while the output word waits
    assign advance  = !valid_reg[STAGES-1] || m_tready;
    assign s_tready = advance;
    assign m_tvalid = valid_reg[STAGES-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (advance)
        begin
            valid_reg <= {valid_reg[STAGES-2:0], s_tvalid};
        end
    end

    for (genvar c = 0; c < NCH; c++)
    begin : g_chan
        localparam int BASE = c * hogob_pkg::NUM_TAPS * SAMPLE_BITS;
        hogob_chan_lane #(
            .SAMPLE_BITS (SAMPLE_BITS)
        ) u_lane (
            .clk      (clk),
            .en       (advance),
            .shift    (shift_reg),
            .next_row (s_tdata[BASE +: SAMPLE_BITS]),
            .prev_row (s_tdata[BASE + SAMPLE_BITS +: SAMPLE_BITS]),
            .next_col (s_tdata[BASE + 2 * SAMPLE_BITS +: SAMPLE_BITS]),
            .prev_col (s_tdata[BASE + 3 * SAMPLE_BITS +: SAMPLE_BITS]),
            .gx_reg   (ch_gx[c]),
            .gy_reg   (ch_gy[c]),
            .mag_reg  (ch_mag[c])
        );
    end

    hogob_chan_select #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_select (
        .clk     (clk),
        .en      (advance),
        .gx      (ch_gx),
        .gy      (ch_gy),
        .mag     (ch_mag),
        .gx_reg  (sel_gx),
        .gy_reg  (sel_gy),
        .mag_reg (sel_mag)
    );

    for (genvar d = 0; d < NDIR; d++)
    begin : g_dir
        hogob_dir_lane #(
            .SAMPLE_BITS (SAMPLE_BITS),
            .DIR         (d)
        ) u_dir (
            .clk     (clk),
            .en      (advance),
            .gx      (sel_gx),
            .gy      (sel_gy),
            .val_reg (dir_val[d]),
            .bin_reg (dir_bin[d])
        );
    end

    hogob_bin_merge #(
        .VAL_W (DW)
    ) u_merge (
        .clk     (clk),
        .en      (advance),
        .val     (dir_val),
        .bin     (dir_bin),
        .bin_reg (out_bin)
    );

    // carry the chosen gradient alongside the direction lanes and merge tree
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            dgx_reg  <= {dgx_reg[DLY-2:0], sel_gx};
            dgy_reg  <= {dgy_reg[DLY-2:0], sel_gy};
            dmag_reg <= {dmag_reg[DLY-2:0], sel_mag};
        end
    end

    // an element of a packed array reads as unsigned: restore the sign first
    assign mag_ext = 32'(dmag_reg[DLY-1]);
    assign gx_ext  = 32'(signed'(dgx_reg[DLY-1]));
    assign gy_ext  = 32'(signed'(dgy_reg[DLY-1]));

    assign m_tdata = {PAD_W'(0),
                      gy_ext[hogob_pkg::W_GRAD-1:0],
                      gx_ext[hogob_pkg::W_GRAD-1:0],
                      mag_ext[hogob_pkg::W_MAG-1:0],
                      out_bin};

endmodule
